### rtl/core/hpt_pkg.sv
// hpt_pkg: shared types and constants for the HDR pixel tone mapper.
// Payload structs, the configuration record, register indexes and reset values.
// No dependencies.
`default_nettype none

package hpt_pkg;

    localparam int SUM_WIDTH_DEF   = 32;
    localparam int GAMMA_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam int FIELD_W   = 32;
    localparam int CODE_W    = 8;
    localparam int COUNT_W   = 11;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int FRAC_BITS = 20;

    localparam logic [CODE_W-1:0] CODE_MAX = 8'hFF;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE_GAIN = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_MODE     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA_MODE    = 4'd3;

    localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT  = 11'd10;
    localparam logic [GAIN_W-1:0]  RST_EXPOSURE_GAIN = 16'd4096;

    typedef struct packed {
        logic [FIELD_W-1:0] sum_red;
        logic [FIELD_W-1:0] sum_green;
        logic [FIELD_W-1:0] sum_blue;
    } pixel_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_red;
        logic [CODE_W-1:0] out_green;
        logic [CODE_W-1:0] out_blue;
    } code_t;

    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic [GAIN_W-1:0]  exposure_gain;
        logic               tone_mode;
        logic               gamma_mode;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/core/hdr_pixel_tonemap_gamma.sv
// HDR pixel tone mapper with gamma, 8-bit display codes per channel.
// The averaging divider takes SUM_WIDTH stages, the Reinhard divider 20; both are
// fully pipelined. Throughput: one pixel per cycle while code_ready is high.
// Reset: asynchronous, active low; clears valid state and restores register defaults.
// The gamma ROM is constant and needs no fill after reset.
`default_nettype none

module hdr_pixel_tonemap_gamma #(
    parameter int SUM_WIDTH         = hpt_pkg::SUM_WIDTH_DEF,
    parameter int GAMMA_TABLE_DEPTH = hpt_pkg::GAMMA_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  hpt_pkg::pixel_t                     pix,
    output logic                                code_valid,
    input  logic                                code_ready,
    output hpt_pkg::code_t                      code,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hpt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hpt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AVW = 3 * SUM_WIDTH;

    hpt_pkg::cfg_t  cfg_reg, cfg_next;

    logic           fr_valid;
    logic           q_ready;
    logic [AVW-1:0] fr_word;
    logic           bk_valid;
    logic           bk_ready;
    logic [AVW-1:0] bk_word;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                hpt_pkg::CFG_SAMPLE_COUNT:
                    cfg_next.sample_count = cfg_data[hpt_pkg::COUNT_W-1:0];
                hpt_pkg::CFG_EXPOSURE_GAIN:
                    cfg_next.exposure_gain = cfg_data[hpt_pkg::GAIN_W-1:0];
                hpt_pkg::CFG_TONE_MODE:
                    cfg_next.tone_mode = cfg_data[0];
                hpt_pkg::CFG_GAMMA_MODE:
                    cfg_next.gamma_mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count  <= hpt_pkg::RST_SAMPLE_COUNT;
            cfg_reg.exposure_gain <= hpt_pkg::RST_EXPOSURE_GAIN;
            cfg_reg.tone_mode     <= 1'b0;
            cfg_reg.gamma_mode    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hpt_front #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_count (cfg_reg.sample_count),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready),
        .pix          (pix),
        .avg_valid    (fr_valid),
        .avg_ready    (q_ready),
        .avg          (fr_word)
    );

    hpt_queue #(
        .WIDTH (AVW),
        .DEPTH (hpt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (q_ready),
        .in_data   (fr_word),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_word)
    );

    hpt_back #(
        .SUM_WIDTH         (SUM_WIDTH),
        .GAMMA_TABLE_DEPTH (GAMMA_TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .avg_valid  (bk_valid),
        .avg_ready  (bk_ready),
        .avg        (bk_word),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

    // an empty queue always has room
    a_queue_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_valid |-> q_ready)
        else $error("queue empty but not ready");

    // the front only stalls the input when the queue is full
    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> !q_ready)
        else $error("front stalled with room in queue");

    // the back only stalls when a finished word is held at the output
    a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_ready |-> code_valid)
        else $error("back stalled without a held output word");

endmodule

`default_nettype wire

### rtl/core/hpt_front.sv
// hpt_front: accepts pixels and averages each channel over the sample count.
// Pipelined restoring divider, one quotient bit per stage. Uses hpt_pkg.
`default_nettype none

module hpt_front #(
    parameter int SUM_WIDTH = hpt_pkg::SUM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hpt_pkg::COUNT_W-1:0]     sample_count,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  hpt_pkg::pixel_t                 pix,
    output logic                            avg_valid,
    input  logic                            avg_ready,
    output logic [3*SUM_WIDTH-1:0]          avg
);

    localparam int CW = hpt_pkg::COUNT_W;
    localparam int NS = SUM_WIDTH;

    logic                 adv;
    logic [CW-1:0]        div;
    logic [NS-1:0]        vld_reg;
    logic [SUM_WIDTH-1:0] sum_in  [3];
    logic [SUM_WIDTH-1:0] w_reg   [NS][3];
    logic [CW-1:0]        rem_reg [NS][3];

    // a zero count divides by one
    assign div       = (sample_count == '0) ? CW'(1) : sample_count;
    assign adv       = !vld_reg[NS-1] || avg_ready;
    assign pix_ready = adv;
    assign avg_valid = vld_reg[NS-1];

    always_comb
    begin
        sum_in[0] = SUM_WIDTH'(pix.sum_red);
        sum_in[1] = SUM_WIDTH'(pix.sum_green);
        sum_in[2] = SUM_WIDTH'(pix.sum_blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], pix_valid};
        end
    end

    // dividend shifts out the top while quotient bits shift in at the bottom
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        for (genvar c = 0; c < 3; c++)
        begin : g_ch
            logic [SUM_WIDTH-1:0] w_src;
            logic [CW-1:0]        r_src;
            logic [CW:0]          sh;
            logic [CW:0]          diff;
            logic                 ge;
            logic [SUM_WIDTH-1:0] w_next;
            logic [CW-1:0]        r_next;

            if (s == 0)
            begin : g_first
                assign w_src = sum_in[c];
                assign r_src = '0;
            end
            else
            begin : g_rest
                assign w_src = w_reg[s-1][c];
                assign r_src = rem_reg[s-1][c];
            end

            always_comb
            begin
                sh     = {r_src, w_src[SUM_WIDTH-1]};
                ge     = sh >= {1'b0, div};
                diff   = sh - {1'b0, div};
                r_next = ge ? diff[CW-1:0] : sh[CW-1:0];
                w_next = {w_src[SUM_WIDTH-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    w_reg[s][c]   <= w_next;
                    rem_reg[s][c] <= r_next;
                end
            end
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_out
        assign avg[c*SUM_WIDTH +: SUM_WIDTH] = w_reg[NS-1][c];
    end

endmodule

`default_nettype wire

### rtl/core/hpt_queue.sv
// hpt_queue: short word queue between the averaging front and the tone back.
// Register array with read and write pointers. Uses hpt_pkg for the default depth.
`default_nettype none

module hpt_queue #(
    parameter int WIDTH = 3 * hpt_pkg::SUM_WIDTH_DEF,
    parameter int DEPTH = hpt_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             wr, rd;

    assign in_ready  = cnt_reg != NW'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hpt_gamma_rom.sv
// hpt_gamma_rom: gamma 1/2.2 code ROM with registered read. Uses hpt_pkg.
// Entry i is the largest k up to 255 with k^11 * (D-1)^5 <= 256^11 * i^5.
`default_nettype none

module hpt_gamma_rom #(
    parameter int DEPTH = hpt_pkg::GAMMA_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    output logic [hpt_pkg::CODE_W-1:0]   data
);

    localparam int BW       = 192;
    localparam int CODE_EXP = 11;
    localparam int IDX_EXP  = 5;
    localparam int SCALE_SH = CODE_EXP * hpt_pkg::CODE_W;

    function automatic logic [BW-1:0] pow_big(input int base, input int ex);
        logic [BW-1:0] acc;
        int            n;
        acc = BW'(1);
        for (n = 0; n < ex; n++)
        begin
            acc = acc * BW'(base);
        end
        return acc;
    endfunction

    function automatic logic [8*DEPTH-1:0] build_rom();
        logic [8*DEPTH-1:0] bits;
        logic [BW-1:0]      top5;
        logic [BW-1:0]      rhs;
        int                 k;
        int                 i;
        bits = '0;
        top5 = pow_big(DEPTH - 1, IDX_EXP);
        k    = 0;
        for (i = 0; i < DEPTH; i++)
        begin
            rhs = pow_big(i, IDX_EXP) << SCALE_SH;
            while (k < 255 && (pow_big(k + 1, CODE_EXP) * top5) <= rhs)
            begin
                k = k + 1;
            end
            bits[8*i +: 8] = 8'(k);
        end
        return bits;
    endfunction

    localparam logic [8*DEPTH-1:0] ROM_BITS = build_rom();

    logic [hpt_pkg::CODE_W-1:0] data_reg;

    assign data = data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM_BITS[{addr, 3'b000} +: 8];
        end
    end

endmodule

`default_nettype wire

### rtl/core/hpt_back.sv
// hpt_back: exposure, tone map, gamma index and code output for averaged pixels.
// Multiply stage, Reinhard divider (one bit per stage), index, ROM, output register.
// Gamma mode takes a square-root code path. Uses hpt_pkg and hpt_gamma_rom.
`default_nettype none

module hpt_back #(
    parameter int SUM_WIDTH         = hpt_pkg::SUM_WIDTH_DEF,
    parameter int GAMMA_TABLE_DEPTH = hpt_pkg::GAMMA_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hpt_pkg::cfg_t          cfg,
    input  logic                   avg_valid,
    output logic                   avg_ready,
    input  logic [3*SUM_WIDTH-1:0] avg,
    output logic                   code_valid,
    input  logic                   code_ready,
    output hpt_pkg::code_t         code
);

    localparam int FRAC = hpt_pkg::FRAC_BITS;
    localparam int GW   = hpt_pkg::GAIN_W;
    localparam int GF   = hpt_pkg::GAIN_FRAC;
    localparam int PRW  = SUM_WIDTH + GW;
    localparam int MW   = SUM_WIDTH + GW - GF;
    localparam int DW   = MW + 1;
    localparam int NDIV = FRAC;
    localparam int AW   = $clog2(GAMMA_TABLE_DEPTH);
    localparam int TW   = FRAC + 1;
    localparam int IPW  = TW + AW + 1;
    localparam int NB   = NDIV + 4;

    localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC;
    localparam logic [DW-1:0] D_ONE = DW'(1) << FRAC;

    logic          adv;
    logic [NB-1:0] vld_reg;

    logic [DW-1:0]   d_reg    [NDIV+1][3];
    logic [DW-1:0]   r_reg    [NDIV+1][3];
    logic [FRAC-1:0] q_reg    [NDIV+1][3];
    logic [TW-1:0]   tlin_reg [NDIV+1][3];
    logic [7:0]      sq_reg   [NDIV+3][3];
    logic [AW-1:0]   idx_reg  [3];
    logic [7:0]      rom_data [3];
    logic [7:0]      out_reg  [3];

    // floor(sqrt(v)), two radicand bits per step
    function automatic logic [7:0] isqrt16(input logic [15:0] v);
        logic [11:0] rem;
        logic [11:0] trial;
        logic [7:0]  root;
        int          i;
        rem  = '0;
        root = '0;
        for (i = 0; i < 8; i++)
        begin
            rem   = {rem[9:0], v[15-2*i -: 2]};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[6:0], 1'b1};
            end
            else
            begin
                root = {root[6:0], 1'b0};
            end
        end
        return root;
    endfunction

    assign adv        = !vld_reg[NB-1] || code_ready;
    assign avg_ready  = adv;
    assign code_valid = vld_reg[NB-1];

    assign code.out_red   = out_reg[0];
    assign code.out_green = out_reg[1];
    assign code.out_blue  = out_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NB-2:0], avg_valid};
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        logic [SUM_WIDTH-1:0] a;
        logic [PRW-1:0]       prod;
        logic [MW-1:0]        m;
        logic [63:0]          a64;
        logic [63:0]          m64;
        logic [TW-1:0]        t;
        logic [IPW-1:0]       iprod;
        logic [AW+1:0]        iraw;

        // exposure and the square-root path side by side
        always_comb
        begin
            a    = avg[c*SUM_WIDTH +: SUM_WIDTH];
            prod = PRW'(a) * PRW'(cfg.exposure_gain);
            m    = prod[PRW-1:GF];
            a64  = 64'(a);
            m64  = 64'(m);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[0][c]    <= DW'(m) + D_ONE;
                r_reg[0][c]    <= DW'(m);
                q_reg[0][c]    <= '0;
                tlin_reg[0][c] <= (|m64[63:FRAC]) ? T_ONE : TW'(m64[FRAC-1:0]);
                sq_reg[0][c]   <= (|a64[63:FRAC]) ? hpt_pkg::CODE_MAX
                                                  : isqrt16(a64[FRAC-1:4]);
            end
        end

        // Reinhard: q = floor(m * 2^20 / (m + 2^20)); m < d so no integer part
        for (genvar s = 1; s <= NDIV; s++)
        begin : g_div
            logic [DW:0]   sh;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] r_next;

            always_comb
            begin
                sh     = {r_reg[s-1][c], 1'b0};
                ge     = sh >= {1'b0, d_reg[s-1][c]};
                diff   = sh - {1'b0, d_reg[s-1][c]};
                r_next = ge ? diff[DW-1:0] : sh[DW-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d_reg[s][c]    <= d_reg[s-1][c];
                    r_reg[s][c]    <= r_next;
                    q_reg[s][c]    <= {q_reg[s-1][c][FRAC-2:0], ge};
                    tlin_reg[s][c] <= tlin_reg[s-1][c];
                    sq_reg[s][c]   <= sq_reg[s-1][c];
                end
            end
        end

        // table index, rounded half up
        always_comb
        begin
            t     = cfg.tone_mode ? {1'b0, q_reg[NDIV][c]} : tlin_reg[NDIV][c];
            iprod = IPW'(t) * IPW'(GAMMA_TABLE_DEPTH - 1) + (IPW'(1) << (FRAC - 1));
            iraw  = iprod[IPW-1:FRAC];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                idx_reg[c]        <= (iraw > (AW+2)'(GAMMA_TABLE_DEPTH - 1))
                                     ? AW'(GAMMA_TABLE_DEPTH - 1) : iraw[AW-1:0];
                sq_reg[NDIV+1][c] <= sq_reg[NDIV][c];
                sq_reg[NDIV+2][c] <= sq_reg[NDIV+1][c];
                out_reg[c]        <= cfg.gamma_mode ? sq_reg[NDIV+2][c] : rom_data[c];
            end
        end

        hpt_gamma_rom #(
            .DEPTH (GAMMA_TABLE_DEPTH)
        ) u_rom (
            .clk  (clk),
            .en   (adv),
            .addr (idx_reg[c]),
            .data (rom_data[c])
        );
    end

endmodule

`default_nettype wire

### verif/tb.sv
// tb: self-checking testbench for hdr_pixel_tonemap_gamma.
// Uses hpt_pkg for the payload types and register indexes; needs only the RTL.
// Predicts each pixel's display codes with its own exact integer model.
`default_nettype none

module tb;
    import hpt_pkg::*;

    localparam int DEPTH    = GAMMA_DEPTH_DEF;
    localparam int LATENCY  = SUM_WIDTH_DEF + 24;
    localparam int N_RANDOM = 1000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    pixel_t pix = '0;
    logic code_valid;
    logic code_ready = 1'b0;
    code_t code;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit hold_off = 1'b0;
    bit stall_enable = 1'b0;

    hdr_pixel_tonemap_gamma dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
        .code_valid(code_valid), .code_ready(code_ready), .code(code),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Exact integer model of the tone map and gamma path.
    class code_scoreboard;
        logic [7:0] gamma_rom [DEPTH];
        logic [COUNT_W-1:0] sample_count;
        logic [GAIN_W-1:0] exposure_gain;
        bit tone_mode;
        bit gamma_mode;
        code_t pending[$];
        int errors;
        int n_checked;

        function new();
            errors = 0;
            n_checked = 0;
            restore_defaults();
            build_rom();
        endfunction

        function void restore_defaults();
            sample_count = RST_SAMPLE_COUNT;
            exposure_gain = RST_EXPOSURE_GAIN;
            tone_mode = 1'b0;
            gamma_mode = 1'b0;
        endfunction

        // (k/256)^11 <= (i/(D-1))^5, in wide integers
        function bit code_fits(int k, int i);
            logic [191:0] lhs;
            logic [191:0] rhs;
            lhs = 1;
            rhs = 1;
            for (int n = 0; n < 11; n++)
            begin
                lhs = lhs * k;
                rhs = rhs * 256;
            end
            for (int n = 0; n < 5; n++)
            begin
                lhs = lhs * (DEPTH - 1);
                rhs = rhs * i;
            end
            return lhs <= rhs;
        endfunction

        function void build_rom();
            int k;
            k = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                while (k < 255 && code_fits(k + 1, i))
                    k++;
                gamma_rom[i] = k[7:0];
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SAMPLE_COUNT:  sample_count = data[COUNT_W-1:0];
                CFG_EXPOSURE_GAIN: exposure_gain = data[GAIN_W-1:0];
                CFG_TONE_MODE:     tone_mode = data[0];
                CFG_GAMMA_MODE:    gamma_mode = data[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] channel_code(logic [31:0] sum);
            logic [63:0] avg;
            logic [63:0] scaled;
            logic [63:0] toned;
            logic [63:0] den;
            logic [63:0] idx;
            logic [63:0] root;
            logic [63:0] trial;
            avg = sum / ((sample_count == 0) ? 64'd1 : 64'(sample_count));
            if (gamma_mode)
            begin
                if (avg >= (64'd1 << FRAC_BITS))
                    return CODE_MAX;
                root = 0;
                for (int b = 7; b >= 0; b--)
                begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= (avg >> 4))
                        root = trial;
                end
                return root[7:0];
            end
            scaled = (avg * exposure_gain) >> GAIN_FRAC;
            if (!tone_mode)
                toned = (scaled < (64'd1 << FRAC_BITS)) ? scaled : (64'd1 << FRAC_BITS);
            else
            begin
                den = (64'd1 << FRAC_BITS) + scaled;
                toned = (64'd1 << FRAC_BITS) - (((64'd1 << 40) + den - 1) / den);
            end
            idx = (toned * (DEPTH - 1) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (idx > DEPTH - 1)
                idx = DEPTH - 1;
            return gamma_rom[idx];
        endfunction

        function void note_pixel(pixel_t p);
            code_t c;
            c.out_red = channel_code(p.sum_red);
            c.out_green = channel_code(p.sum_green);
            c.out_blue = channel_code(p.sum_blue);
            pending.push_back(c);
        endfunction

        function void check_code(code_t got);
            code_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected code word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.out_red !== want.out_red)
            begin
                $error("out_red expected %0d actual %0d", want.out_red, got.out_red);
                errors++;
            end
            if (got.out_green !== want.out_green)
            begin
                $error("out_green expected %0d actual %0d", want.out_green, got.out_green);
                errors++;
            end
            if (got.out_blue !== want.out_blue)
            begin
                $error("out_blue expected %0d actual %0d", want.out_blue, got.out_blue);
                errors++;
            end
        endfunction
    endclass

    code_scoreboard sb = new();

    // monitors sample on the same edge the handshake completes
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
            sb.note_pixel(pix);
        if (rst_n && code_valid && code_ready)
            sb.check_code(code);
    end

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            code_ready <= 1'b0;
        else if (stall_enable)
            code_ready <= ($urandom_range(0, 9) < 7);
        else
            code_ready <= 1'b1;
    end

    int burst_left = 0;

    // valid stays up between words of a burst; it only drops for a gap
    task automatic send_pixel(pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = stall_enable ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_valid <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
    endtask

    task automatic send_burst_word(pixel_t p);
        pix_valid <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        pix_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_config(int count, int gain, bit tone, bit gmode);
        wait_idle();
        write_reg(CFG_SAMPLE_COUNT, 16'(count));
        write_reg(CFG_EXPOSURE_GAIN, 16'(gain));
        write_reg(CFG_TONE_MODE, {15'd0, tone});
        write_reg(CFG_GAMMA_MODE, {15'd0, gmode});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sum(int shift_max);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return '0;
            2: return v;
            default: return v >> $urandom_range(0, shift_max);
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.sum_red = rand_sum(31);
        p.sum_green = rand_sum(31);
        p.sum_blue = rand_sum(31);
        return p;
    endfunction

    task automatic directed();
        pixel_t p;
        logic [31:0] vals [8] = '{32'd0, 32'hFFFF_FFFF, 32'h0010_0000, 32'h000A_0000,
                                 32'd1, 32'h0064_0000, 32'h8000_0000, 32'h0000_FFFF};
        for (int i = 0; i < 8; i++)
        begin
            p.sum_red = vals[i];
            p.sum_green = vals[(i + 3) % 8];
            p.sum_blue = vals[(i + 5) % 8];
            send_pixel(p);
        end
    endtask

    initial
    begin
        int cfg_counts [6] = '{1, 1024, 10, 0, 2047, 37};
        int cfg_gains [6] = '{4096, 65535, 0, 4096, 1, 12000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, then tone mode and gamma mode in turn, with extremes
        directed();
        set_config(1, 65535, 1'b1, 1'b0);
        directed();
        set_config(0, 0, 1'b0, 1'b1);
        directed();
        wait_idle();
        // unknown register index must be ignored
        write_reg(4'hF, 16'hFFFF);
        write_reg(CFG_TONE_MODE, 16'hFFFE);
        cfg_valid <= 1'b0;

        stall_enable = 1'b1;
        for (int phase = 0; phase < 6; phase++)
        begin
            set_config(cfg_counts[phase], cfg_gains[phase], phase[0], phase == 2 || phase == 5);
            if (phase == 3)
            begin
                // stall output long enough to back up the pipeline
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (LATENCY * 3) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int i = 0; i < 150; i++)
                            send_burst_word(rand_pixel());
                    end
                join
            end
            for (int i = 0; i < N_RANDOM / 6; i++)
                send_pixel(rand_pixel());
        end
        wait_idle();

        $display("Checked %0d pixel words over six register settings plus directed cases.",
                 sb.n_checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
